>>> sv/dooc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dooc_pkg
// Shared constants, types and helper functions for the dual on/off cycle
// scheduler.
// ----------------------------------------------------------------------------
package dooc_pkg;

   localparam int SECONDS_BITS     = 24;
   localparam int TICKS_PER_SECOND = 1000;
   localparam int TICK_BITS        = $clog2(TICKS_PER_SECOND + 1);
   localparam int PROD_BITS        = SECONDS_BITS + TICK_BITS;
   localparam int PHASE_BITS       = 34;
   localparam int TOTAL_BITS       = SECONDS_BITS + 1;
   localparam int EPOCH_BITS       = 32;
   localparam int EPOCH_CNT_BITS   = $clog2(EPOCH_BITS);
   localparam int ACTION_BITS      = 3;
   localparam int BVAL_BITS        = 16;
   localparam int PCT_BITS         = 7;
   localparam int PCT_FULL         = 100;
   localparam int DUTY_BITS        = 8;
   localparam int DUTY_MAX         = 255;
   localparam int DUTY_SCALED_BITS = 15;
   localparam int DUTY_RECIP       = 5243;
   localparam int DUTY_SHIFT       = 19;
   localparam int DUTY_PROD_BITS   = 28;
   localparam int NUM_CH           = 2;

   localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;

   localparam logic [ACTION_BITS-1:0] ACT_TICK        = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_BRIGHT      = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_LIGHT_SCHED = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_IRRIG_SCHED = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_RECOVER     = 3'd4;

   localparam logic CH_LIGHT = 1'b0;
   localparam logic CH_IRRIG = 1'b1;

   typedef struct packed {
      logic                    active;
      logic                    in_on;
      logic [SECONDS_BITS-1:0] on_len;
      logic [SECONDS_BITS-1:0] off_len;
      logic [EPOCH_BITS-1:0]   anchor;
      logic [PHASE_BITS-1:0]   phase_ms;
      logic [PHASE_BITS-1:0]   on_lim;
      logic [PHASE_BITS-1:0]   off_lim;
   } chan_type;

   function automatic logic [PHASE_BITS-1:0] ticks_of(input logic [SECONDS_BITS-1:0] secs);
      logic [PROD_BITS-1:0] prod;
      prod = PROD_BITS'(secs) * PROD_BITS'(TICKS_PER_SECOND);
      if (prod > PROD_BITS'(PHASE_MAX)) begin
         return PHASE_MAX;
      end
      return PHASE_BITS'(prod);
   endfunction

   // floor(b * 255 / 100) through a reciprocal multiply
   function automatic logic [DUTY_BITS-1:0] duty_of(input logic [PCT_BITS-1:0] pct);
      logic [DUTY_SCALED_BITS-1:0] scaled;
      logic [DUTY_PROD_BITS-1:0]   prod;
      scaled = DUTY_SCALED_BITS'(pct) * DUTY_SCALED_BITS'(DUTY_MAX);
      prod   = DUTY_PROD_BITS'(scaled) * DUTY_PROD_BITS'(DUTY_RECIP);
      return prod[DUTY_SHIFT +: DUTY_BITS];
   endfunction

endpackage

>>> sv/dual_on_off_cycle_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_on_off_cycle_scheduler_top
// Two-channel on/off cycle scheduler: light brightness with PWM duty and an
// irrigation relay, driven by millisecond ticks and commands.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one response. For a tick, a
// brightness command, an unknown action or a schedule command that starts no
// schedule, an execute step is followed by the response step. A schedule
// command that starts a schedule adds a multiply step for the on length and
// one for the off length, as the shared multiplier turns them into tick
// limits one after the other. A recover command checks each channel in an
// init step and, for a channel with an active anchored schedule, runs a
// restoring divider one quotient bit per cycle, then a position step and a
// multiply step. The request port is ready again as soon as the response is
// loaded into the output register, so the next request can be taken in the
// cycle the response appears; a stalled response holds the block in its last step.
module dual_on_off_cycle_scheduler_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dooc_pkg::ACTION_BITS-1:0]     req_action,
   input  logic signed [dooc_pkg::BVAL_BITS-1:0] req_brightness_value,
   input  logic                                 req_schedule_active,
   input  logic [dooc_pkg::SECONDS_BITS-1:0]    req_on_seconds,
   input  logic [dooc_pkg::SECONDS_BITS-1:0]    req_off_seconds,
   input  logic                                 req_off_first,
   input  logic [dooc_pkg::EPOCH_BITS-1:0]      req_start_epoch,
   input  logic [dooc_pkg::EPOCH_BITS-1:0]      req_now_epoch,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dooc_pkg::DUTY_BITS-1:0]       rsp_light_duty,
   output logic [dooc_pkg::PCT_BITS-1:0]        rsp_brightness,
   output logic                                 rsp_light_on,
   output logic                                 rsp_irrigation_on,
   output logic                                 rsp_light_sched_on,
   output logic                                 rsp_irrig_sched_on,
   output logic                                 rsp_changed
);
   import dooc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_MUL_ON,
      S_MUL_OFF,
      S_REC_INIT,
      S_REC_DIV,
      S_REC_POS,
      S_REC_MUL,
      S_DONE
   } state_type;

   state_type                     state_ff, state_in;
   chan_type                      chan_ff [NUM_CH];
   chan_type                      chan_in [NUM_CH];
   logic [PCT_BITS-1:0]           bright_ff, bright_in;
   logic                          lit_ff, lit_in;
   logic                          relay_ff, relay_in;
   logic                          changed_ff, changed_in;
   logic                          ch_ff, ch_in;

   logic [ACTION_BITS-1:0]        act_ff, act_in;
   logic signed [BVAL_BITS-1:0]   bval_ff, bval_in;
   logic                          sa_ff, sa_in;
   logic [SECONDS_BITS-1:0]       on_s_ff, on_s_in;
   logic [SECONDS_BITS-1:0]       off_s_ff, off_s_in;
   logic                          st_off_ff, st_off_in;
   logic [EPOCH_BITS-1:0]         start_ff, start_in;
   logic [EPOCH_BITS-1:0]         now_ff, now_in;

   logic [EPOCH_BITS-1:0]         div_num_ff, div_num_in;
   logic [TOTAL_BITS-1:0]         rem_ff, rem_in;
   logic [TOTAL_BITS-1:0]         total_ff, total_in;
   logic [EPOCH_CNT_BITS-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [SECONDS_BITS-1:0]       mul_arg_ff, mul_arg_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0]          rsp_duty_ff, rsp_duty_in;
   logic [PCT_BITS-1:0]           rsp_bright_ff, rsp_bright_in;
   logic                          rsp_lit_ff, rsp_lit_in;
   logic                          rsp_relay_ff, rsp_relay_in;
   logic                          rsp_lsched_ff, rsp_lsched_in;
   logic                          rsp_isched_ff, rsp_isched_in;
   logic                          rsp_changed_ff, rsp_changed_in;

   logic [PHASE_BITS-1:0]         tick_cnt [NUM_CH];
   logic                          tick_due [NUM_CH];
   logic [PHASE_BITS-1:0]         mul_ticks;
   logic [PCT_BITS-1:0]           clamp_pct;
   logic                          sch;
   chan_type                      sel;
   chan_type                      cur;
   logic                          sched_diff;
   logic                          first_on;
   logic                          new_on;
   logic [TOTAL_BITS-1:0]         total_sum;
   logic [TOTAL_BITS:0]           trial;
   logic [TOTAL_BITS-1:0]         on_ext;

   assign req_ready = (state_ff == S_IDLE);

   // per-channel tick counter and phase end
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         tick_cnt[c] = (chan_ff[c].phase_ms != PHASE_MAX) ?
                       chan_ff[c].phase_ms + PHASE_BITS'(1) : chan_ff[c].phase_ms;
         tick_due[c] = tick_cnt[c] >= (chan_ff[c].in_on ? chan_ff[c].on_lim :
                                                          chan_ff[c].off_lim);
      end
   end

   // shared seconds to ticks multiplier
   assign mul_ticks = ticks_of(mul_arg_ff);

   always_comb begin
      if (bval_ff[BVAL_BITS-1]) begin
         clamp_pct = '0;
      end else if (bval_ff > BVAL_BITS'(PCT_FULL)) begin
         clamp_pct = PCT_BITS'(PCT_FULL);
      end else begin
         clamp_pct = bval_ff[PCT_BITS-1:0];
      end
   end

   assign sch        = (act_ff == ACT_IRRIG_SCHED) ? CH_IRRIG : CH_LIGHT;
   assign sel        = chan_ff[sch];
   assign cur        = chan_ff[ch_ff];
   assign sched_diff = (sel.active != sa_ff) || (sel.on_len != on_s_ff) ||
                       (sel.off_len != off_s_ff) || (sel.anchor != start_ff);
   assign first_on   = !st_off_ff;
   assign new_on     = first_on ^ (first_on ? (on_s_ff == '0) : (off_s_ff == '0));
   assign total_sum  = TOTAL_BITS'(cur.on_len) + TOTAL_BITS'(cur.off_len);
   assign trial      = {rem_ff, div_num_ff[EPOCH_BITS-1]};
   assign on_ext     = TOTAL_BITS'(cur.on_len);

   always_comb begin
      state_in       = state_ff;
      chan_in        = chan_ff;
      bright_in      = bright_ff;
      lit_in         = lit_ff;
      relay_in       = relay_ff;
      changed_in     = changed_ff;
      ch_in          = ch_ff;
      act_in         = act_ff;
      bval_in        = bval_ff;
      sa_in          = sa_ff;
      on_s_in        = on_s_ff;
      off_s_in       = off_s_ff;
      st_off_in      = st_off_ff;
      start_in       = start_ff;
      now_in         = now_ff;
      div_num_in     = div_num_ff;
      rem_in         = rem_ff;
      total_in       = total_ff;
      bit_cnt_in     = bit_cnt_ff;
      mul_arg_in     = mul_arg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_duty_in    = rsp_duty_ff;
      rsp_bright_in  = rsp_bright_ff;
      rsp_lit_in     = rsp_lit_ff;
      rsp_relay_in   = rsp_relay_ff;
      rsp_lsched_in  = rsp_lsched_ff;
      rsp_isched_in  = rsp_isched_ff;
      rsp_changed_in = rsp_changed_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in     = req_action;
               bval_in    = req_brightness_value;
               sa_in      = req_schedule_active;
               on_s_in    = req_on_seconds;
               off_s_in   = req_off_seconds;
               st_off_in  = req_off_first;
               start_in   = req_start_epoch;
               now_in     = req_now_epoch;
               changed_in = 1'b0;
               state_in   = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            unique case (act_ff)
               ACT_TICK: begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     if (chan_ff[c].active) begin
                        if (tick_due[c]) begin
                           chan_in[c].in_on    = !chan_ff[c].in_on;
                           chan_in[c].phase_ms = '0;
                           changed_in          = 1'b1;
                        end else begin
                           chan_in[c].phase_ms = tick_cnt[c];
                        end
                     end
                  end
                  if (chan_ff[CH_LIGHT].active && tick_due[CH_LIGHT]) begin
                     bright_in = chan_ff[CH_LIGHT].in_on ? '0 : PCT_BITS'(PCT_FULL);
                     lit_in    = !chan_ff[CH_LIGHT].in_on;
                  end
                  if (chan_ff[CH_IRRIG].active && tick_due[CH_IRRIG]) begin
                     relay_in = !chan_ff[CH_IRRIG].in_on;
                  end
               end
               ACT_BRIGHT: begin
                  if ((bright_ff != clamp_pct) || chan_ff[CH_LIGHT].active) begin
                     bright_in                = clamp_pct;
                     lit_in                   = (clamp_pct != '0);
                     chan_in[CH_LIGHT].active = 1'b0;
                     changed_in               = 1'b1;
                  end
               end
               ACT_LIGHT_SCHED, ACT_IRRIG_SCHED: begin
                  if (sched_diff) begin
                     changed_in          = 1'b1;
                     chan_in[sch].active = sa_ff;
                     if (sa_ff) begin
                        chan_in[sch].on_len   = on_s_ff;
                        chan_in[sch].off_len  = off_s_ff;
                        chan_in[sch].anchor   = start_ff;
                        chan_in[sch].in_on    = new_on;
                        chan_in[sch].phase_ms = '0;
                        if (sch == CH_LIGHT) begin
                           bright_in = new_on ? PCT_BITS'(PCT_FULL) : '0;
                           lit_in    = new_on;
                        end else begin
                           relay_in = new_on;
                        end
                        ch_in      = sch;
                        mul_arg_in = on_s_ff;
                        state_in   = S_MUL_ON;
                     end else begin
                        if (sch == CH_LIGHT) begin
                           bright_in = '0;
                           lit_in    = 1'b0;
                        end else begin
                           relay_in = 1'b0;
                        end
                     end
                  end
               end
               ACT_RECOVER: begin
                  changed_in = 1'b1;
                  ch_in      = CH_LIGHT;
                  state_in   = S_REC_INIT;
               end
               default: begin
               end
            endcase
         end

         S_MUL_ON: begin
            chan_in[ch_ff].on_lim = mul_ticks;
            mul_arg_in            = cur.off_len;
            state_in              = S_MUL_OFF;
         end

         S_MUL_OFF: begin
            chan_in[ch_ff].off_lim = mul_ticks;
            state_in               = S_DONE;
         end

         S_REC_INIT: begin
            if (cur.active && (cur.anchor != '0) && (total_sum != '0)) begin
               div_num_in = now_ff - cur.anchor;
               total_in   = total_sum;
               rem_in     = '0;
               bit_cnt_in = '0;
               state_in   = S_REC_DIV;
            end else if (ch_ff == CH_IRRIG) begin
               state_in = S_DONE;
            end else begin
               ch_in = CH_IRRIG;
            end
         end

         S_REC_DIV: begin
            if (trial >= {1'b0, total_ff}) begin
               rem_in = TOTAL_BITS'(trial - {1'b0, total_ff});
            end else begin
               rem_in = trial[TOTAL_BITS-1:0];
            end
            div_num_in = div_num_ff << 1;
            bit_cnt_in = bit_cnt_ff + EPOCH_CNT_BITS'(1);
            if (bit_cnt_ff == EPOCH_CNT_BITS'(EPOCH_BITS - 1)) begin
               state_in = S_REC_POS;
            end
         end

         S_REC_POS: begin
            if (rem_ff < on_ext) begin
               chan_in[ch_ff].in_on = 1'b1;
               mul_arg_in           = rem_ff[SECONDS_BITS-1:0];
            end else begin
               chan_in[ch_ff].in_on = 1'b0;
               mul_arg_in           = SECONDS_BITS'(rem_ff - on_ext);
            end
            state_in = S_REC_MUL;
         end

         S_REC_MUL: begin
            chan_in[ch_ff].phase_ms = mul_ticks;
            if (ch_ff == CH_LIGHT) begin
               bright_in = cur.in_on ? PCT_BITS'(PCT_FULL) : '0;
               lit_in    = cur.in_on;
               ch_in     = CH_IRRIG;
               state_in  = S_REC_INIT;
            end else begin
               relay_in = cur.in_on;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_duty_in    = duty_of(bright_ff);
               rsp_bright_in  = bright_ff;
               rsp_lit_in     = lit_ff;
               rsp_relay_in   = relay_ff;
               rsp_lsched_in  = chan_ff[CH_LIGHT].active;
               rsp_isched_in  = chan_ff[CH_IRRIG].active;
               rsp_changed_in = changed_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CH; c++) begin
            chan_ff[c] <= '0;
         end
         bright_ff  <= '0;
         lit_ff     <= 1'b0;
         relay_ff   <= 1'b0;
         changed_ff <= 1'b0;
         ch_ff      <= CH_LIGHT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chan_ff      <= chan_in;
         bright_ff    <= bright_in;
         lit_ff       <= lit_in;
         relay_ff     <= relay_in;
         changed_ff   <= changed_in;
         ch_ff        <= ch_in;
      end
      act_ff         <= act_in;
      bval_ff        <= bval_in;
      sa_ff          <= sa_in;
      on_s_ff        <= on_s_in;
      off_s_ff       <= off_s_in;
      st_off_ff      <= st_off_in;
      start_ff       <= start_in;
      now_ff         <= now_in;
      div_num_ff     <= div_num_in;
      rem_ff         <= rem_in;
      total_ff       <= total_in;
      bit_cnt_ff     <= bit_cnt_in;
      mul_arg_ff     <= mul_arg_in;
      rsp_duty_ff    <= rsp_duty_in;
      rsp_bright_ff  <= rsp_bright_in;
      rsp_lit_ff     <= rsp_lit_in;
      rsp_relay_ff   <= rsp_relay_in;
      rsp_lsched_ff  <= rsp_lsched_in;
      rsp_isched_ff  <= rsp_isched_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_light_duty     = rsp_duty_ff;
   assign rsp_brightness     = rsp_bright_ff;
   assign rsp_light_on       = rsp_lit_ff;
   assign rsp_irrigation_on  = rsp_relay_ff;
   assign rsp_light_sched_on = rsp_lsched_ff;
   assign rsp_irrig_sched_on = rsp_isched_ff;
   assign rsp_changed        = rsp_changed_ff;

endmodule

>>> sv/dooc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dooc_checker
// Port-level checks for the dual on/off cycle scheduler, bound to its top.
// ----------------------------------------------------------------------------
module dooc_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic [dooc_pkg::ACTION_BITS-1:0]      req_action,
   input logic signed [dooc_pkg::BVAL_BITS-1:0] req_brightness_value,
   input logic                                  req_schedule_active,
   input logic [dooc_pkg::SECONDS_BITS-1:0]     req_on_seconds,
   input logic [dooc_pkg::SECONDS_BITS-1:0]     req_off_seconds,
   input logic                                  req_off_first,
   input logic [dooc_pkg::EPOCH_BITS-1:0]       req_start_epoch,
   input logic [dooc_pkg::EPOCH_BITS-1:0]       req_now_epoch,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [dooc_pkg::DUTY_BITS-1:0]        rsp_light_duty,
   input logic [dooc_pkg::PCT_BITS-1:0]         rsp_brightness,
   input logic                                  rsp_light_on,
   input logic                                  rsp_irrigation_on,
   input logic                                  rsp_light_sched_on,
   input logic                                  rsp_irrig_sched_on,
   input logic                                  rsp_changed
);
   import dooc_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_light_duty) &&
      $stable(rsp_brightness) && $stable(rsp_changed))
      else $error("stalled response changed");

   // one request in flight
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_bright_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_brightness <= PCT_BITS'(PCT_FULL))
      else $error("brightness out of range");

   a_lit_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_light_on == (rsp_brightness != '0))
      else $error("light on flag disagrees with brightness");

   a_duty_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_brightness != '0 || rsp_light_duty == '0) &&
      (rsp_brightness != PCT_BITS'(PCT_FULL) || rsp_light_duty == DUTY_BITS'(DUTY_MAX)))
      else $error("duty does not match brightness end points");

endmodule

bind dual_on_off_cycle_scheduler_top dooc_checker u_dooc_checker (.*);

>>> dv/dual_on_off_cycle_scheduler_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_on_off_cycle_scheduler_top_tb
// Self-checking bench for the dual on/off cycle scheduler. A short table of
// requests covers clamping, unknown actions, zero-length phases and recover
// edge cases. Random episodes follow: schedules with ticks and recovers,
// brightness overrides, noise, and one run of ticks long enough to cross a
// one-second phase. A behavioral model of both channels predicts each
// response that the table does not give, and the responses are checked in
// order. Both sides of the handshake idle at random.
// ----------------------------------------------------------------------------
module dual_on_off_cycle_scheduler_top_tb;
   import dooc_pkg::*;

   localparam logic [ACTION_BITS-1:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [ACTION_BITS-1:0] ACT_SPARE_LAST  = 3'd7;

   localparam int IDLE_PCT     = 25;
   localparam int ITEMS_TOTAL  = 1270;
   localparam int LONG_TICKS   = 1005;
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PLAN_LEN     = 25;

   typedef struct packed {
      logic [ACTION_BITS-1:0]      action;
      logic signed [BVAL_BITS-1:0] bval;
      logic                        sched_active;
      logic [SECONDS_BITS-1:0]     on_s;
      logic [SECONDS_BITS-1:0]     off_s;
      logic                        off_first;
      logic [EPOCH_BITS-1:0]       start_epoch;
      logic [EPOCH_BITS-1:0]       now_epoch;
   } cmd_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] duty;
      logic [PCT_BITS-1:0]  bright;
      logic                 light_on;
      logic                 irrig_on;
      logic                 light_sched;
      logic                 irrig_sched;
      logic                 changed;
   } status_type;

   typedef struct packed {
      cmd_type    cmd;
      logic       typed;
      status_type want;
   } plan_row_type;

   typedef struct packed {
      logic                    active;
      logic                    in_on;
      logic [SECONDS_BITS-1:0] on_len;
      logic [SECONDS_BITS-1:0] off_len;
      logic [EPOCH_BITS-1:0]   anchor;
      logic [PHASE_BITS-1:0]   phase_ms;
   } cycle_type;

   localparam status_type ALL_OFF = '0;

   localparam plan_row_type PLAN [PLAN_LEN] = '{
      '{'{ACT_TICK, 0, 0, 0, 0, 0, 0, 0}, 1, ALL_OFF},
      '{'{ACT_SPARE_LAST, 16'sh7FFF, 1, 24'hFFFFFF, 24'hFFFFFF, 1, 32'hFFFFFFFF,
          32'hFFFFFFFF}, 1, ALL_OFF},
      '{'{ACT_BRIGHT, 16'sh7FFF, 0, 0, 0, 0, 0, 0}, 1, '{255, 100, 1, 0, 0, 0, 1}},
      '{'{ACT_BRIGHT, 16'sd100, 0, 0, 0, 0, 0, 0}, 1, '{255, 100, 1, 0, 0, 0, 0}},
      '{'{ACT_BRIGHT, 16'sh8000, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, 0, 0, 1}},
      '{'{ACT_BRIGHT, 16'sd0, 0, 0, 0, 0, 0, 0}, 1, ALL_OFF},
      '{'{ACT_BRIGHT, 16'sd1, 0, 0, 0, 0, 0, 0}, 1, '{2, 1, 1, 0, 0, 0, 1}},
      '{'{ACT_BRIGHT, 16'sd99, 0, 0, 0, 0, 0, 0}, 1, '{252, 99, 1, 0, 0, 0, 1}},
      '{'{ACT_BRIGHT, 16'sd101, 0, 0, 0, 0, 0, 0}, 1, '{255, 100, 1, 0, 0, 0, 1}},
      '{'{ACT_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 0}, 1, '{255, 100, 1, 0, 0, 0, 0}},
      // zero-length phases flip at once and on every tick
      '{'{ACT_LIGHT_SCHED, 0, 1, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_IRRIG_SCHED, 0, 1, 24'd1, 0, 1, 32'd5, 0}, 0, ALL_OFF},
      '{'{ACT_IRRIG_SCHED, 0, 1, 24'd1, 0, 1, 32'd5, 0}, 0, ALL_OFF},
      // light anchor unknown, irrigation anchor wraps
      '{'{ACT_RECOVER, 0, 0, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_TICK, 0, 0, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_LIGHT_SCHED, 0, 1, 24'hFFFFFF, 24'hFFFFFF, 0, 32'hFFFFFFFF, 0}, 0, ALL_OFF},
      '{'{ACT_RECOVER, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF}, 0, ALL_OFF},
      '{'{ACT_RECOVER, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF}, 0, ALL_OFF},
      // manual brightness cancels the running schedule
      '{'{ACT_BRIGHT, 16'sd50, 0, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_LIGHT_SCHED, 0, 0, 0, 0, 0, 0, 0}, 0, ALL_OFF},
      '{'{ACT_IRRIG_SCHED, 0, 0, 24'd1, 0, 1, 32'd5, 0}, 0, ALL_OFF},
      '{'{ACT_RECOVER, 0, 0, 0, 0, 0, 0, 32'd123}, 0, ALL_OFF},
      '{'{ACT_LIGHT_SCHED, 0, 1, 24'd3, 24'd2, 1, 32'd1000, 0}, 0, ALL_OFF}
   };

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [ACTION_BITS-1:0]      req_action;
   logic signed [BVAL_BITS-1:0] req_brightness_value;
   logic                        req_schedule_active;
   logic [SECONDS_BITS-1:0]     req_on_seconds;
   logic [SECONDS_BITS-1:0]     req_off_seconds;
   logic                        req_off_first;
   logic [EPOCH_BITS-1:0]       req_start_epoch;
   logic [EPOCH_BITS-1:0]       req_now_epoch;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [DUTY_BITS-1:0]        rsp_light_duty;
   logic [PCT_BITS-1:0]         rsp_brightness;
   logic                        rsp_light_on;
   logic                        rsp_irrigation_on;
   logic                        rsp_light_sched_on;
   logic                        rsp_irrig_sched_on;
   logic                        rsp_changed;

   logic                        calm;
   status_type                  outstanding [$];
   status_type                  head;
   cycle_type                   chans [NUM_CH];
   logic [PCT_BITS-1:0]         level;
   logic                        lit;
   logic                        relay;
   int                          errors;
   int                          checked;
   int                          toggles;
   int                          known_items;
   int                          ignored_items;
   int                          by_action [8];
   int unsigned                 cycle_count = 0;

   dual_on_off_cycle_scheduler_top DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_brightness_value (req_brightness_value),
      .req_schedule_active  (req_schedule_active),
      .req_on_seconds       (req_on_seconds),
      .req_off_seconds      (req_off_seconds),
      .req_off_first        (req_off_first),
      .req_start_epoch      (req_start_epoch),
      .req_now_epoch        (req_now_epoch),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_light_duty       (rsp_light_duty),
      .rsp_brightness       (rsp_brightness),
      .rsp_light_on         (rsp_light_on),
      .rsp_irrigation_on    (rsp_irrigation_on),
      .rsp_light_sched_on   (rsp_light_sched_on),
      .rsp_irrig_sched_on   (rsp_irrig_sched_on),
      .rsp_changed          (rsp_changed)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---- channel model ----

   function automatic logic [PHASE_BITS-1:0] secs_to_ticks(input logic [EPOCH_BITS-1:0] secs);
      longint unsigned t;
      t = 64'(secs) * 64'(TICKS_PER_SECOND);
      return (t > 64'(PHASE_MAX)) ? PHASE_MAX : PHASE_BITS'(t);
   endfunction

   function automatic logic phase_done(input cycle_type t);
      longint unsigned lim;
      lim = 64'(t.in_on ? t.on_len : t.off_len) * 64'(TICKS_PER_SECOND);
      return 64'(t.phase_ms) >= lim;
   endfunction

   function automatic void follow_phase(input int i);
      if (i == int'(CH_LIGHT)) begin
         level = chans[i].in_on ? PCT_BITS'(PCT_FULL) : '0;
         lit   = chans[i].in_on;
      end else begin
         relay = chans[i].in_on;
      end
   endfunction

   task automatic advance_model(input cmd_type c, output status_type s);
      logic                    changed;
      logic [PCT_BITS-1:0]     pct;
      int                      ch;
      int                      i;
      logic [TOTAL_BITS-1:0]   span;
      logic [EPOCH_BITS-1:0]   pos;
      changed = 1'b0;
      case (c.action)
         ACT_TICK: begin
            for (i = 0; i < NUM_CH; i++) begin
               if (chans[i].active) begin
                  if (chans[i].phase_ms != PHASE_MAX) chans[i].phase_ms++;
                  if (phase_done(chans[i])) begin
                     chans[i].in_on    = !chans[i].in_on;
                     chans[i].phase_ms = '0;
                     follow_phase(i);
                     changed = 1'b1;
                     toggles++;
                  end
               end
            end
         end
         ACT_BRIGHT: begin
            if (c.bval[BVAL_BITS-1]) begin
               pct = '0;
            end else if (c.bval > BVAL_BITS'(PCT_FULL)) begin
               pct = PCT_BITS'(PCT_FULL);
            end else begin
               pct = c.bval[PCT_BITS-1:0];
            end
            if (level != pct || chans[CH_LIGHT].active) begin
               level                   = pct;
               lit                     = (pct != 0);
               chans[CH_LIGHT].active  = 1'b0;
               changed                 = 1'b1;
            end
         end
         ACT_LIGHT_SCHED, ACT_IRRIG_SCHED: begin
            ch = (c.action == ACT_LIGHT_SCHED) ? int'(CH_LIGHT) : int'(CH_IRRIG);
            if (chans[ch].active != c.sched_active || chans[ch].on_len != c.on_s ||
                chans[ch].off_len != c.off_s || chans[ch].anchor != c.start_epoch) begin
               chans[ch].active = c.sched_active;
               if (c.sched_active) begin
                  chans[ch].on_len   = c.on_s;
                  chans[ch].off_len  = c.off_s;
                  chans[ch].anchor   = c.start_epoch;
                  chans[ch].in_on    = !c.off_first;
                  chans[ch].phase_ms = '0;
                  if (phase_done(chans[ch])) chans[ch].in_on = !chans[ch].in_on;
                  follow_phase(ch);
               end else if (ch == int'(CH_LIGHT)) begin
                  level = '0;
                  lit   = 1'b0;
               end else begin
                  relay = 1'b0;
               end
               changed = 1'b1;
            end
         end
         ACT_RECOVER: begin
            for (i = 0; i < NUM_CH; i++) begin
               span = TOTAL_BITS'(chans[i].on_len) + TOTAL_BITS'(chans[i].off_len);
               if (chans[i].active && chans[i].anchor != 0 && span != 0) begin
                  pos = (c.now_epoch - chans[i].anchor) % EPOCH_BITS'(span);
                  if (pos < chans[i].on_len) begin
                     chans[i].in_on    = 1'b1;
                     chans[i].phase_ms = secs_to_ticks(pos);
                  end else begin
                     chans[i].in_on    = 1'b0;
                     chans[i].phase_ms = secs_to_ticks(pos - chans[i].on_len);
                  end
                  follow_phase(i);
               end
            end
            changed = 1'b1;
         end
         default: begin
         end
      endcase
      s.duty        = DUTY_BITS'((int'(level) * DUTY_MAX) / PCT_FULL);
      s.bright      = level;
      s.light_on    = lit;
      s.irrig_on    = relay;
      s.light_sched = chans[CH_LIGHT].active;
      s.irrig_sched = chans[CH_IRRIG].active;
      s.changed     = changed;
   endtask

   // ---- request generation ----

   function automatic cmd_type noise_cmd();
      cmd_type c;
      c.action       = ACTION_BITS'($urandom_range(ACT_TICK, ACT_SPARE_LAST));
      c.bval         = BVAL_BITS'($urandom);
      c.sched_active = 1'($urandom);
      c.on_s         = SECONDS_BITS'($urandom);
      c.off_s        = SECONDS_BITS'($urandom);
      c.off_first    = 1'($urandom);
      c.start_epoch  = $urandom;
      c.now_epoch    = $urandom;
      return c;
   endfunction

   function automatic cmd_type tick_cmd();
      cmd_type c;
      c        = noise_cmd();
      c.action = ACT_TICK;
      return c;
   endfunction

   function automatic logic [SECONDS_BITS-1:0] pick_secs();
      case ($urandom_range(0, 9))
         0, 1:       return '0;
         2, 3, 4, 5: return SECONDS_BITS'($urandom_range(1, 3));
         6:          return '1;
         7:          return SECONDS_BITS'($urandom_range(4, 600));
         default:    return SECONDS_BITS'($urandom);
      endcase
   endfunction

   task automatic issue(input cmd_type c, input logic typed, input status_type typed_want);
      status_type pred;
      req_valid            <= 1'b1;
      req_action           <= c.action;
      req_brightness_value <= c.bval;
      req_schedule_active  <= c.sched_active;
      req_on_seconds       <= c.on_s;
      req_off_seconds      <= c.off_s;
      req_off_first        <= c.off_first;
      req_start_epoch      <= c.start_epoch;
      req_now_epoch        <= c.now_epoch;
      do @(posedge clock); while (!req_ready);
      advance_model(c, pred);
      outstanding.push_back(typed ? typed_want : pred);
      by_action[c.action]++;
      if (c.action <= ACT_RECOVER) known_items++;
      else ignored_items++;
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // ---- response checking ----

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (outstanding.size() == 0) begin
            errors++;
            $error("response transfer with nothing expected");
         end else begin
            head = outstanding.pop_front();
            checked++;
            check_field("light_duty", 32'(head.duty), 32'(rsp_light_duty));
            check_field("brightness", 32'(head.bright), 32'(rsp_brightness));
            check_field("light_on", 32'(head.light_on), 32'(rsp_light_on));
            check_field("irrigation_on", 32'(head.irrig_on), 32'(rsp_irrigation_on));
            check_field("light_sched_on", 32'(head.light_sched), 32'(rsp_light_sched_on));
            check_field("irrig_sched_on", 32'(head.irrig_sched), 32'(rsp_irrig_sched_on));
            check_field("changed", 32'(head.changed), 32'(rsp_changed));
         end
      end
   end

   // ---- stimulus ----

   initial begin : stimulus
      cmd_type c;
      cmd_type sched;
      int   i;
      int   long_at;
      logic long_done;

      reset                <= 1'b1;
      calm                 <= 1'b0;
      req_valid            <= 1'b0;
      req_action           <= ACT_TICK;
      req_brightness_value <= '0;
      req_schedule_active  <= 1'b0;
      req_on_seconds       <= '0;
      req_off_seconds      <= '0;
      req_off_first        <= 1'b0;
      req_start_epoch      <= '0;
      req_now_epoch        <= '0;
      errors        = 0;
      checked       = 0;
      toggles       = 0;
      known_items   = 0;
      ignored_items = 0;
      foreach (by_action[k]) by_action[k] = 0;
      chans[CH_LIGHT] = '0;
      chans[CH_IRRIG] = '0;
      level     = '0;
      lit       = 1'b0;
      relay     = 1'b0;
      long_done = 1'b0;
      long_at   = $urandom_range(150, 500);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_LEN; i++) begin
         issue(PLAN[i].cmd, PLAN[i].typed, PLAN[i].want);
      end

      while (known_items < ITEMS_TOTAL) begin
         if (!long_done && known_items >= long_at) begin
            // one-second phases need a thousand ticks to run out
            calm <= 1'b1;
            c              = noise_cmd();
            c.action       = ACT_LIGHT_SCHED;
            c.sched_active = 1'b1;
            c.on_s         = 1;
            c.off_s        = SECONDS_BITS'($urandom_range(0, 1));
            c.off_first    = 1'b0;
            c.start_epoch  = $urandom | 32'h1;
            issue(c, 1'b0, ALL_OFF);
            c.action       = ACT_IRRIG_SCHED;
            c.on_s         = SECONDS_BITS'($urandom_range(0, 1));
            c.off_s        = 1;
            c.off_first    = 1'b1;
            issue(c, 1'b0, ALL_OFF);
            repeat (LONG_TICKS) issue(tick_cmd(), 1'b0, ALL_OFF);
            calm <= 1'b0;
            long_done = 1'b1;
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               sched              = noise_cmd();
               sched.action       = $urandom_range(0, 1) ? ACT_LIGHT_SCHED : ACT_IRRIG_SCHED;
               sched.sched_active = ($urandom_range(0, 7) != 0);
               sched.on_s         = pick_secs();
               sched.off_s        = pick_secs();
               sched.start_epoch  = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
               issue(sched, 1'b0, ALL_OFF);
               // same schedule again should leave the phase alone
               if ($urandom_range(0, 3) == 0) issue(sched, 1'b0, ALL_OFF);
               repeat ($urandom_range(0, 6)) issue(tick_cmd(), 1'b0, ALL_OFF);
               if ($urandom_range(0, 1)) begin
                  c        = noise_cmd();
                  c.action = ACT_RECOVER;
                  if ($urandom_range(0, 2) != 0) begin
                     c.now_epoch = sched.start_epoch + $urandom_range(0,
                        2 * (32'(sched.on_s) + 32'(sched.off_s)) + 2);
                  end
                  issue(c, 1'b0, ALL_OFF);
                  repeat ($urandom_range(0, 4)) issue(tick_cmd(), 1'b0, ALL_OFF);
               end
            end
            6, 7: begin
               repeat ($urandom_range(1, 4)) begin
                  c        = noise_cmd();
                  c.action = ACT_BRIGHT;
                  if ($urandom_range(0, 2) != 0) begin
                     c.bval = BVAL_BITS'(int'($urandom_range(0, PCT_FULL + 15)) - 5);
                  end
                  issue(c, 1'b0, ALL_OFF);
               end
            end
            default: begin
               repeat ($urandom_range(1, 3)) issue(noise_cmd(), 1'b0, ALL_OFF);
            end
         endcase
      end
      req_valid <= 1'b0;

      while (outstanding.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("requests sent: %0d ticks, %0d brightness, %0d light and %0d irrigation schedules,",
               by_action[ACT_TICK], by_action[ACT_BRIGHT], by_action[ACT_LIGHT_SCHED],
               by_action[ACT_IRRIG_SCHED]);
      $display("%0d recovers, %0d unknown actions; %0d responses checked, %0d phase flips",
               by_action[ACT_RECOVER], ignored_items, checked, toggles);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
